@@ design/kts_pkg.sv @@
// Shared types, codes and helpers of the keyframe track sampler.
`timescale 1ns / 1ps
`default_nettype none
package kts_pkg;

  localparam int KEYS_DEF   = 64;
  localparam int DIV_STEPS  = 18;
  localparam int SQRT_STEPS = 32;

  localparam logic [2:0] FN_CLR = 3'd0;
  localparam logic [2:0] FN_LDS = 3'd1;
  localparam logic [2:0] FN_LDR = 3'd2;
  localparam logic [2:0] FN_LDP = 3'd3;
  localparam logic [2:0] FN_SMP = 3'd4;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef struct packed {
    logic [2:0]         func;
    logic [31:0]        time_ticks;
    logic signed [31:0] val_x;
    logic signed [31:0] val_y;
    logic signed [31:0] val_z;
    logic signed [31:0] val_w;
  } kts_in_t;

  typedef struct packed {
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } kts_out_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_EXEC, OP_IDENT, OP_SCAN_INIT, OP_TRD, OP_SCAN,
    OP_DIV_NORM, OP_DIV_STEP, OP_BLEND_SET, OP_VRD_A, OP_VRD_B, OP_LAT_B,
    OP_SQ, OP_SQ_ACC, OP_SQRT_INIT, OP_SQRT_STEP, OP_NZERO, OP_NSET,
    OP_DOT, OP_DOT_ACC, OP_LERP_MUL, OP_LERP_ADD
  } kts_op_t;

  typedef struct packed {
    kts_op_t    op;
    logic [1:0] trk;
    logic [1:0] k;
    logic       sel;
  } kts_cmd_t;

  typedef struct packed {
    logic [2:0] empty;
    logic       go_rd;
    logic       go_div;
    logic       r_zero;
  } kts_sts_t;

  function automatic logic [3:0] res_base(input logic [1:0] trk);
    case (trk)
      2'd0:    res_base = 4'd0;
      2'd1:    res_base = 4'd3;
      default: res_base = 4'd7;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ design/kts_dp.sv @@
// Datapath: key stores, segment scan, shared divider, square root and multiplier.
`timescale 1ns / 1ps
`default_nettype none
module kts_dp #(
  parameter int KEYS = kts_pkg::KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kts_pkg::kts_in_t  in_data,
  input  kts_pkg::kts_cmd_t cmd,
  output kts_pkg::kts_sts_t sts,
  output kts_pkg::kts_out_t out_data
);
  import kts_pkg::*;

  localparam int IW    = $clog2(KEYS);
  localparam int CW    = $clog2(KEYS + 1);
  localparam int DEPTH = 3 * KEYS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] KEYS_A = AW'(KEYS);

  logic [31:0]  tmem [DEPTH];
  logic [127:0] vmem [DEPTH];

  kts_in_t            in_r;
  logic [CW-1:0]      cnt_r [3];
  logic [IW-1:0]      idx_r, i0_r, i1_r;
  logic [31:0]        tk_r, t0_r;
  logic [15:0]        blend_r;
  logic [127:0]       vrd_r;
  logic signed [31:0] a_r [4];
  logic signed [31:0] b_r [4];
  logic signed [17:0] na_r [4];
  logic signed [17:0] nb_r [4];
  logic [31:0]        div_rem_r, div_den_r;
  logic [17:0]        div_num_r, div_q_r;
  logic [64:0]        acc_r;
  logic [63:0]        sq_v_r;
  logic [33:0]        sq_rem_r;
  logic [31:0]        sq_res_r;
  logic signed [65:0] prod_r;
  logic signed [35:0] dot_r;
  logic [31:0]        res_r [10];

  logic [1:0]         ld_trk;
  logic               ld_wr;
  logic [CW-1:0]      n_cur;
  logic [AW-1:0]      trk_base, waddr, raddr;
  logic               seg, at_last;
  logic [31:0]        dt;
  logic signed [31:0] qk;
  logic [31:0]        mag;
  logic [32:0]        div_trial;
  logic [35:0]        sq_rem2, sq_trial;
  logic signed [32:0] ak, bk, diff, mul_a, mul_b;
  logic [3:0]         ridx;
  logic [17:0]        qsat;

  assign ld_trk   = in_r.func[1:0] - 2'd1;
  assign ld_wr    = (cmd.op == OP_EXEC) && (in_r.func >= FN_LDS) && (in_r.func <= FN_LDP)
                    && (cnt_r[ld_trk] != CW'(KEYS));
  assign n_cur    = cnt_r[cmd.trk];
  assign trk_base = AW'(cmd.trk) * KEYS_A;
  assign waddr    = AW'(ld_trk) * KEYS_A + AW'(cnt_r[ld_trk]);

  always_comb begin
    case (cmd.op)
      OP_VRD_A: raddr = trk_base + AW'(i0_r);
      OP_VRD_B: raddr = trk_base + AW'(i1_r);
      default:  raddr = trk_base + AW'(idx_r);
    endcase
  end

  assign seg     = (idx_r != '0) && (in_r.time_ticks < tk_r);
  assign at_last = (CW'(idx_r) + CW'(1)) == n_cur;
  assign dt      = in_r.time_ticks - t0_r;

  assign sts.empty[0] = cnt_r[0] == '0;
  assign sts.empty[1] = cnt_r[1] == '0;
  assign sts.empty[2] = cnt_r[2] == '0;
  assign sts.go_rd    = !seg && !at_last;
  assign sts.go_div   = seg && (in_r.time_ticks > t0_r) && (tk_r > t0_r);
  assign sts.r_zero   = sq_res_r == '0;

  assign qk  = cmd.sel ? b_r[cmd.k] : a_r[cmd.k];
  assign mag = qk[31] ? (~qk + 32'd1) : qk;

  assign div_trial = {div_rem_r, div_num_r[17]};
  assign sq_rem2   = {sq_rem_r, sq_v_r[63:62]};
  assign sq_trial  = {2'b00, sq_res_r, 2'b01};
  assign qsat      = (div_q_r > 18'd65536) ? 18'd65536 : div_q_r;
  assign ridx      = res_base(cmd.trk) + 4'(cmd.k);

  always_comb begin
    if (cmd.trk == 2'd1) begin
      ak = 33'(na_r[cmd.k]);
      bk = dot_r[35] ? -33'(nb_r[cmd.k]) : 33'(nb_r[cmd.k]);
    end else begin
      ak = 33'(a_r[cmd.k]);
      bk = 33'(b_r[cmd.k]);
    end
    diff = bk - ak;
    case (cmd.op)
      OP_SQ: begin
        mul_a = $signed({1'b0, mag});
        mul_b = $signed({1'b0, mag});
      end
      OP_DOT: begin
        mul_a = 33'(na_r[cmd.k]);
        mul_b = 33'(nb_r[cmd.k]);
      end
      default: begin
        mul_a = diff;
        mul_b = $signed({17'd0, blend_r});
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld_wr) begin
      tmem[waddr] <= in_r.time_ticks;
      vmem[waddr] <= {in_r.val_x, in_r.val_y, in_r.val_z, in_r.val_w};
    end
    if (cmd.op == OP_TRD) begin
      tk_r <= tmem[raddr];
    end
    if ((cmd.op == OP_VRD_A) || (cmd.op == OP_VRD_B)) begin
      vrd_r <= vmem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r[0] <= '0;
      cnt_r[1] <= '0;
      cnt_r[2] <= '0;
    end else if (cmd.op == OP_EXEC) begin
      if (in_r.func == FN_CLR) begin
        cnt_r[0] <= '0;
        cnt_r[1] <= '0;
        cnt_r[2] <= '0;
      end else if (ld_wr) begin
        cnt_r[ld_trk] <= cnt_r[ld_trk] + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op) inside
      OP_LATCH: in_r <= in_data;
      OP_IDENT: begin
        case (cmd.trk)
          2'd0: begin
            res_r[0] <= ONE_Q16;
            res_r[1] <= ONE_Q16;
            res_r[2] <= ONE_Q16;
          end
          2'd1: begin
            res_r[3] <= '0;
            res_r[4] <= '0;
            res_r[5] <= '0;
            res_r[6] <= ONE_Q16;
          end
          default: begin
            res_r[7] <= '0;
            res_r[8] <= '0;
            res_r[9] <= '0;
          end
        endcase
      end
      OP_SCAN_INIT: begin
        idx_r   <= '0;
        i0_r    <= IW'(n_cur - CW'(1));
        i1_r    <= IW'(n_cur - CW'(1));
        blend_r <= '0;
        acc_r   <= '0;
        dot_r   <= '0;
      end
      OP_SCAN: begin
        if (seg) begin
          i0_r <= idx_r - IW'(1);
          i1_r <= idx_r;
          div_rem_r <= {2'b00, dt[31:2]};
          div_num_r <= {dt[1:0], 16'h0000};
          div_den_r <= tk_r - t0_r;
        end else begin
          t0_r  <= tk_r;
          idx_r <= idx_r + IW'(1);
        end
      end
      OP_DIV_NORM: begin
        div_rem_r <= {3'b000, mag[31:3]};
        div_num_r <= {mag[2:0], 15'h0000};
        div_den_r <= sq_res_r;
      end
      OP_DIV_STEP: begin
        if (div_trial >= {1'b0, div_den_r}) begin
          div_rem_r <= 32'(div_trial - {1'b0, div_den_r});
          div_q_r   <= {div_q_r[16:0], 1'b1};
        end else begin
          div_rem_r <= div_trial[31:0];
          div_q_r   <= {div_q_r[16:0], 1'b0};
        end
        div_num_r <= {div_num_r[16:0], 1'b0};
      end
      OP_BLEND_SET: blend_r <= div_q_r[15:0];
      OP_VRD_B: begin
        a_r[0] <= vrd_r[127:96];
        a_r[1] <= vrd_r[95:64];
        a_r[2] <= vrd_r[63:32];
        a_r[3] <= vrd_r[31:0];
      end
      OP_LAT_B: begin
        b_r[0] <= vrd_r[127:96];
        b_r[1] <= vrd_r[95:64];
        b_r[2] <= vrd_r[63:32];
        b_r[3] <= vrd_r[31:0];
      end
      OP_SQ, OP_DOT, OP_LERP_MUL: prod_r <= mul_a * mul_b;
      OP_SQ_ACC: acc_r <= acc_r + {1'b0, prod_r[63:0]};
      OP_SQRT_INIT: begin
        sq_v_r   <= {1'b0, acc_r[64:2]};
        sq_rem_r <= '0;
        sq_res_r <= '0;
        acc_r    <= '0;
      end
      OP_SQRT_STEP: begin
        if (sq_rem2 >= sq_trial) begin
          sq_rem_r <= 34'(sq_rem2 - sq_trial);
          sq_res_r <= {sq_res_r[30:0], 1'b1};
        end else begin
          sq_rem_r <= sq_rem2[33:0];
          sq_res_r <= {sq_res_r[30:0], 1'b0};
        end
        sq_v_r <= {sq_v_r[61:0], 2'b00};
      end
      OP_NZERO: begin
        if (cmd.sel) begin
          nb_r[0] <= '0;
          nb_r[1] <= '0;
          nb_r[2] <= '0;
          nb_r[3] <= 18'sd65536;
        end else begin
          na_r[0] <= '0;
          na_r[1] <= '0;
          na_r[2] <= '0;
          na_r[3] <= 18'sd65536;
        end
      end
      OP_NSET: begin
        if (cmd.sel) begin
          nb_r[cmd.k] <= qk[31] ? -$signed(qsat) : $signed(qsat);
        end else begin
          na_r[cmd.k] <= qk[31] ? -$signed(qsat) : $signed(qsat);
        end
      end
      OP_DOT_ACC: dot_r <= dot_r + prod_r[35:0];
      OP_LERP_ADD: res_r[ridx] <= ak[31:0] + prod_r[47:16];
      default: ;
    endcase
  end

  assign out_data.scale_x = res_r[0];
  assign out_data.scale_y = res_r[1];
  assign out_data.scale_z = res_r[2];
  assign out_data.rot_x   = res_r[3];
  assign out_data.rot_y   = res_r[4];
  assign out_data.rot_z   = res_r[5];
  assign out_data.rot_w   = res_r[6];
  assign out_data.pos_x   = res_r[7];
  assign out_data.pos_y   = res_r[8];
  assign out_data.pos_z   = res_r[9];

endmodule
`default_nettype wire

@@ design/kts_ctrl.sv @@
// Controller: sequences load, clear and the per-track sample steps.
`timescale 1ns / 1ps
`default_nettype none
module kts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_func,
  input  kts_pkg::kts_sts_t sts,
  output kts_pkg::kts_cmd_t cmd,
  output logic              busy,
  output logic              out_valid
);
  import kts_pkg::*;

  typedef enum logic [22:0] {
    ST_IDLE   = 23'd1 << 0,
    ST_EXEC   = 23'd1 << 1,
    ST_TRK    = 23'd1 << 2,
    ST_RD     = 23'd1 << 3,
    ST_CMP    = 23'd1 << 4,
    ST_DIV    = 23'd1 << 5,
    ST_BSET   = 23'd1 << 6,
    ST_VA     = 23'd1 << 7,
    ST_VB     = 23'd1 << 8,
    ST_LB     = 23'd1 << 9,
    ST_SQ     = 23'd1 << 10,
    ST_SQACC  = 23'd1 << 11,
    ST_SQRT0  = 23'd1 << 12,
    ST_SQRT   = 23'd1 << 13,
    ST_NCHK   = 23'd1 << 14,
    ST_NDIV   = 23'd1 << 15,
    ST_NSET   = 23'd1 << 16,
    ST_DOT    = 23'd1 << 17,
    ST_DOTACC = 23'd1 << 18,
    ST_LMUL   = 23'd1 << 19,
    ST_LADD   = 23'd1 << 20,
    ST_NEXT   = 23'd1 << 21,
    ST_OUT    = 23'd1 << 22
  } kts_state_t;

  kts_state_t state_r, state_nxt;
  logic [1:0] trk_r, trk_nxt, k_r, k_nxt;
  logic       sel_r, sel_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  kts_op_t    op;

  assign cmd.op    = op;
  assign cmd.trk   = trk_r;
  assign cmd.k     = k_r;
  assign cmd.sel   = sel_r;
  assign busy      = state_r != ST_IDLE;
  assign out_valid = state_r == ST_OUT;

  always_comb begin
    state_nxt = state_r;
    trk_nxt   = trk_r;
    k_nxt     = k_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    op        = OP_NOP;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op = OP_LATCH;
          if (in_func == FN_SMP) begin
            trk_nxt   = 2'd0;
            state_nxt = ST_TRK;
          end else if (in_func <= FN_LDP) begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        op        = OP_EXEC;
        state_nxt = ST_IDLE;
      end
      ST_TRK: begin
        if (sts.empty[trk_r]) begin
          op        = OP_IDENT;
          state_nxt = ST_NEXT;
        end else begin
          op        = OP_SCAN_INIT;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        op        = OP_TRD;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        op = OP_SCAN;
        if (sts.go_rd) begin
          state_nxt = ST_RD;
        end else if (sts.go_div) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_VA;
        end
      end
      ST_DIV: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = ST_BSET;
        end
      end
      ST_BSET: begin
        op        = OP_BLEND_SET;
        state_nxt = ST_VA;
      end
      ST_VA: begin
        op        = OP_VRD_A;
        state_nxt = ST_VB;
      end
      ST_VB: begin
        op        = OP_VRD_B;
        state_nxt = ST_LB;
      end
      ST_LB: begin
        op      = OP_LAT_B;
        k_nxt   = 2'd0;
        sel_nxt = 1'b0;
        state_nxt = (trk_r == 2'd1) ? ST_SQ : ST_LMUL;
      end
      ST_SQ: begin
        op        = OP_SQ;
        state_nxt = ST_SQACC;
      end
      ST_SQACC: begin
        op    = OP_SQ_ACC;
        k_nxt = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? ST_SQRT0 : ST_SQ;
      end
      ST_SQRT0: begin
        op        = OP_SQRT_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        op      = OP_SQRT_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(SQRT_STEPS - 1)) begin
          state_nxt = ST_NCHK;
        end
      end
      ST_NCHK: begin
        if (sts.r_zero) begin
          op    = OP_NZERO;
          k_nxt = 2'd0;
          if (!sel_r) begin
            sel_nxt   = 1'b1;
            state_nxt = ST_SQ;
          end else begin
            state_nxt = ST_DOT;
          end
        end else begin
          op        = OP_DIV_NORM;
          cnt_nxt   = '0;
          state_nxt = ST_NDIV;
        end
      end
      ST_NDIV: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = ST_NSET;
        end
      end
      ST_NSET: begin
        op    = OP_NSET;
        k_nxt = k_r + 2'd1;
        if (k_r != 2'd3) begin
          state_nxt = ST_NCHK;
        end else if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = ST_SQ;
        end else begin
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: begin
        op        = OP_DOT;
        state_nxt = ST_DOTACC;
      end
      ST_DOTACC: begin
        op    = OP_DOT_ACC;
        k_nxt = k_r + 2'd1;
        state_nxt = (k_r == 2'd3) ? ST_LMUL : ST_DOT;
      end
      ST_LMUL: begin
        op        = OP_LERP_MUL;
        state_nxt = ST_LADD;
      end
      ST_LADD: begin
        op    = OP_LERP_ADD;
        k_nxt = k_r + 2'd1;
        if (k_r == ((trk_r == 2'd1) ? 2'd3 : 2'd2)) begin
          state_nxt = ST_NEXT;
        end else begin
          state_nxt = ST_LMUL;
        end
      end
      ST_NEXT: begin
        trk_nxt   = trk_r + 2'd1;
        state_nxt = (trk_r == 2'd2) ? ST_OUT : ST_TRK;
      end
      ST_OUT: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      trk_r   <= '0;
      k_r     <= '0;
      sel_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      trk_r   <= trk_nxt;
      k_r     <= k_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/keyframe_track_sampler.sv @@
// Top level of the keyframe track sampler: controller plus datapath.
//
// A word is taken on in_data when start is high and busy is low. func selects
// clear, load of a scale, rotation or position key, or sample.
// Clear and load give no result; unused codes are ignored.
// A sample gives one result word on out_data, marked by a one-cycle out_valid
// strobe; the receiver cannot stall and must take it in that cycle.
// Sample steps per track: start the track, a read and a compare per key visited by
// the linear segment scan over the key time memory, the blend divider when a
// segment is interior, the value reads, a multiply and an add per blended
// component, and an advance; an empty track only starts and advances. The rotation
// track adds two quaternion normalizations, each of squaring, the bit-serial square
// root and, per component, the shared 18-step divider (a zero-length key is set to
// the identity instead), plus a dot product. A final state carries the strobe.
// Busy stays high through the strobe; a new word is taken the cycle after it.
// Reset empties all three tracks; key memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_track_sampler #(
  parameter int KEYS = kts_pkg::KEYS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  kts_pkg::kts_in_t in_data,
  output logic             out_valid,
  output kts_pkg::kts_out_t out_data
);
  import kts_pkg::*;

  kts_cmd_t cmd;
  kts_sts_t sts;

  kts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_data.func),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  kts_dp #(
    .KEYS (KEYS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

@@ sim/tb_keyframe_track_sampler.sv @@
// Self-checking testbench of the keyframe track sampler: directed and random words.
`timescale 1ns / 1ps
module tb_keyframe_track_sampler;
  import kts_pkg::*;

  localparam int NKEYS      = KEYS_DEF;
  localparam int CYCLE_CAP  = 6000000;
  localparam int DRAIN_WAIT = 100;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  kts_in_t  in_data;
  logic     out_valid;
  kts_out_t out_data;

  keyframe_track_sampler u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  logic [31:0]      key_time [3][NKEYS];
  logic [3:0][31:0] key_val  [3][NKEYS];
  int               key_cnt  [3];

  kts_out_t pose_q[$];
  int errors, cycles, n_samples, n_loads, n_clears, n_ignored;

  function automatic longint sx(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [31:0] lerp_q16(longint a, longint b, logic [31:0] blend);
    longint d;
    d = (b - a) * longint'({32'd0, blend});
    return 32'(a + (d >>> 16));
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic [3:0][31:0] norm_quat(logic [3:0][31:0] q);
    longint unsigned hi, lo, r, m, d;
    logic [3:0][31:0] n;
    hi = 0;
    lo = 0;
    for (int k = 0; k < 4; k++) begin
      m = sx(q[k]) < 0 ? longint'(-sx(q[k])) : longint'(sx(q[k]));
      hi += (m * m) >> 2;
      lo += (m * m) & 64'd3;
    end
    r = isqrt(hi + (lo >> 2));
    if (r == 0) begin
      n = '0;
      n[3] = ONE_Q16;
      return n;
    end
    for (int k = 0; k < 4; k++) begin
      m = sx(q[k]) < 0 ? longint'(-sx(q[k])) : longint'(sx(q[k]));
      d = (m << 15) / r;
      if (d > 65536) d = 65536;
      n[k] = sx(q[k]) < 0 ? 32'(-longint'(d)) : 32'(d);
    end
    return n;
  endfunction

  function automatic logic [3:0][31:0] sample_track(int trk, logic [31:0] t);
    int n, i0, i1;
    bit found;
    logic [31:0] blend, t0, t1;
    logic [3:0][31:0] a, b, na, nb, res;
    longint dot;
    n = key_cnt[trk];
    res = '0;
    if (n == 0) begin
      if (trk == 0) res[2:0] = {ONE_Q16, ONE_Q16, ONE_Q16};
      if (trk == 1) res[3] = ONE_Q16;
      return res;
    end
    i0 = n - 1;
    i1 = n - 1;
    blend = 0;
    found = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && t < key_time[trk][i+1]) begin
        found = 1;
        t0 = key_time[trk][i];
        t1 = key_time[trk][i+1];
        i0 = i;
        i1 = i + 1;
        if (t > t0 && t1 > t0)
          blend = 32'(({32'd0, t - t0} << 16) / {32'd0, t1 - t0});
      end
    end
    a = key_val[trk][i0];
    b = key_val[trk][i1];
    if (trk == 1) begin
      na = norm_quat(a);
      nb = norm_quat(b);
      dot = 0;
      for (int k = 0; k < 4; k++) dot += sx(na[k]) * sx(nb[k]);
      for (int k = 0; k < 4; k++)
        res[k] = lerp_q16(sx(na[k]), dot < 0 ? -sx(nb[k]) : sx(nb[k]), blend);
    end else begin
      for (int k = 0; k < 3; k++) res[k] = lerp_q16(sx(a[k]), sx(b[k]), blend);
    end
    return res;
  endfunction

  task automatic apply_word(kts_in_t w);
    kts_out_t p;
    logic [3:0][31:0] s, r, q;
    int trk;
    case (w.func) inside
      FN_CLR: begin
        for (int k = 0; k < 3; k++) key_cnt[k] = 0;
        n_clears++;
      end
      FN_LDS, FN_LDR, FN_LDP: begin
        trk = int'(w.func) - 1;
        if (key_cnt[trk] < NKEYS) begin
          key_time[trk][key_cnt[trk]] = w.time_ticks;
          key_val[trk][key_cnt[trk]] = {w.val_w, w.val_z, w.val_y, w.val_x};
          key_cnt[trk]++;
        end
        n_loads++;
      end
      FN_SMP: begin
        s = sample_track(0, w.time_ticks);
        r = sample_track(1, w.time_ticks);
        q = sample_track(2, w.time_ticks);
        p = {s[0], s[1], s[2], r[0], r[1], r[2], r[3], q[0], q[1], q[2]};
        pose_q = {pose_q, p};
        n_samples++;
      end
      default: n_ignored++;
    endcase
  endtask

  task automatic send_word(kts_in_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    apply_word(w);
  endtask

  function automatic kts_in_t mk(logic [2:0] f, logic [31:0] t,
                                 logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, logic [31:0] wv);
    kts_in_t w;
    w.func = f;
    w.time_ticks = t;
    w.val_x = x;
    w.val_y = y;
    w.val_z = z;
    w.val_w = wv;
    return w;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  always @(posedge clk) begin
    logic [9:0][31:0] got, want;
    kts_out_t e;
    if (rst_n && out_valid) begin
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data);
        errors++;
      end else begin
        e = pose_q.pop_front();
        got = out_data;
        want = e;
        for (int k = 9; k >= 0; k--)
          if (got[k] !== want[k]) begin
            $display("%0t: field %0d mismatch expected %h actual %h",
                     $time, 9 - k, want[k], got[k]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("tb_keyframe_track_sampler NOT OK");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(mk(FN_SMP, 32'h0, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'hffff_ffff, 0, 0, 0, 0));
    send_word(mk(FN_LDS, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0002_0000, 5));
    send_word(mk(FN_LDR, 32'h0001_0000, 0, 0, 0, 0));
    send_word(mk(FN_LDP, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000, 7));
    send_word(mk(FN_SMP, 32'h0002_0000, 0, 0, 0, 0));
    send_word(mk(FN_LDS, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff, 32'hfffe_0000, 0));
    send_word(mk(FN_LDR, 32'h0003_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000));
    send_word(mk(FN_LDP, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 0));
    send_word(mk(FN_SMP, 32'h0000_8000, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'h0001_0000, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'h0002_4000, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'hffff_ffff, 0, 0, 0, 0));
    send_word(mk(FN_LDR, 32'h0002_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff));
    send_word(mk(FN_LDR, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
    send_word(mk(FN_SMP, 32'h0002_8000, 0, 0, 0, 0));
    send_word(mk(3'd5, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                 32'hffff_ffff));
    send_word(mk(3'd6, 0, 0, 0, 0, 0));
    send_word(mk(3'd7, 0, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'h0001_8000, 0, 0, 0, 0));
    send_word(mk(FN_CLR, 0, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'h0001_8000, 0, 0, 0, 0));
  endtask

  task automatic test_full_track();
    send_word(mk(FN_CLR, 0, 0, 0, 0, 0));
    for (int i = 0; i < NKEYS + 3; i++) begin
      send_word(mk(FN_LDS, 32'(i * 256), rand_val(), rand_val(), rand_val(), rand_val()));
      send_word(mk(FN_LDR, 32'(i * 256), rand_val(), rand_val(), rand_val(), rand_val()));
      send_word(mk(FN_LDP, 32'(i * 256), rand_val(), rand_val(), rand_val(), rand_val()));
    end
    send_word(mk(FN_SMP, 32'(NKEYS * 256 - 100), 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'hffff_ffff, 0, 0, 0, 0));
    send_word(mk(FN_SMP, 32'd700, 0, 0, 0, 0));
  endtask

  task automatic test_random(int budget);
    int sent, nk;
    logic [31:0] t, tlo, thi;
    logic [2:0] f;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        f = 3'($urandom);
        send_word(mk(f, $urandom, $urandom, $urandom, $urandom, $urandom));
        if (f <= FN_SMP) sent++;
      end else begin
        send_word(mk(FN_CLR, $urandom, $urandom, $urandom, $urandom, $urandom));
        sent++;
        tlo = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
        thi = tlo;
        for (int trk = 0; trk < 3; trk++) begin
          nk = $urandom_range(0, 5);
          t = tlo;
          for (int i = 0; i < nk; i++) begin
            send_word(mk(3'(trk + 1), t, rand_val(), rand_val(), rand_val(), rand_val()));
            sent++;
            if ($urandom_range(0, 9) == 0) t = t - $urandom_range(0, 500);
            else t = t + $urandom_range(0, 9) * $urandom_range(0, 2 ** $urandom_range(0, 20));
            if (t > thi) thi = t;
          end
        end
        for (int s = 0; s < $urandom_range(1, 6); s++) begin
          case ($urandom_range(0, 3))
            0:       t = $urandom;
            1:       t = thi + $urandom_range(0, 100);
            default: t = tlo + 32'($urandom_range(0, 1000) * 64'(thi - tlo + 1) / 1000);
          endcase
          send_word(mk(FN_SMP, t, $urandom, $urandom, $urandom, $urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    n_samples = 0;
    n_loads = 0;
    n_clears = 0;
    n_ignored = 0;
    for (int k = 0; k < 3; k++) key_cnt[k] = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_track();
    test_random(1075);
    start <= 1'b0;
    while (pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d samples, %0d key loads, %0d clears, %0d ignored codes,",
             n_samples, n_loads, n_clears, n_ignored);
    $display("including empty, single-key, full and out-of-range tracks; %0d errors.", errors);
    if (errors == 0) begin
      $display("tb_keyframe_track_sampler OK");
    end else begin
      $display("tb_keyframe_track_sampler NOT OK");
    end
    $finish;
  end

endmodule
